// File: rtl/rv2m_pkg.sv
// ----------------------------------------------------------------------------
// Rotation vector to matrix: shared package
// Stage map, fixed-point constants, carried context type and output clamp.
// ----------------------------------------------------------------------------
package rv2m_pkg;

  localparam int SQRT_STEPS   = 24;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS    = 33;

  // Context stage indices
  localparam int IDX_SQ     = 4;
  localparam int IDX_RED    = IDX_SQ + SQRT_STEPS;
  localparam int IDX_FOLD   = IDX_RED + 1;
  localparam int IDX_COR    = IDX_FOLD + 1;
  localparam int IDX_PREP   = IDX_COR + CORDIC_STEPS;
  localparam int IDX_DIV    = IDX_PREP + 1;
  localparam int CTX_DEPTH  = IDX_DIV + DIV_STEPS;
  // accept to strobe: p1, context, select, multiply, output
  localparam int LATENCY    = CTX_DEPTH + 4;

  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [30:0] HALF_Q30 = 31'h2000_0000;
  localparam logic [29:0] K6       = 30'd715827883;
  localparam logic [27:0] K20      = 28'd214748365;
  localparam logic [27:0] K24      = 28'd178956971;
  localparam logic [47:0] TINY_T   = 48'd10996;
  localparam logic [47:0] SMALL_T  = 48'd1099512;

  localparam logic signed [36:0] PI_Q30      = 37'sd3373259426;
  localparam logic signed [36:0] HALF_PI_Q30 = 37'sd1686629713;
  localparam logic signed [36:0] TWO_PI_Q30  = 37'sd6746518852;
  localparam logic signed [36:0] FOUR_PI_Q30 = TWO_PI_Q30 * 2;
  localparam logic signed [36:0] SIX_PI_Q30  = TWO_PI_Q30 * 3;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  localparam logic signed [39:0] OUT_ONE = 40'sd4194304;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  typedef struct packed {
    logic signed [23:0] wx;
    logic signed [23:0] wy;
    logic signed [23:0] wz;
    logic [47:0]        t;
    logic signed [30:0] d0;
    logic signed [30:0] d1;
    logic signed [30:0] d2;
    logic signed [30:0] cxy;
    logic signed [30:0] cxz;
    logic signed [30:0] cyz;
    logic               tiny;
    logic               gen;
    logic [30:0]        sa;
    logic [30:0]        sb;
    logic [30:0]        sc;
    logic [23:0]        th;
    logic               neg;
    logic               sgn;
  } ctx_t;

  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    logic signed [23:0] r;
    begin
      if (v > OUT_ONE) begin
        r = 24'(OUT_ONE);
      end else if (v < -OUT_ONE) begin
        r = 24'(-OUT_ONE);
      end else begin
        r = v[23:0];
      end
      return r;
    end
  endfunction

endpackage

// File: rtl/rotation_vector_to_matrix_core.sv
// ----------------------------------------------------------------------------
// Rotation vector to rotation matrix core
// Rodrigues' formula on a Q3.20 vector, Q1.22 matrix out, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------
//  input     | start, busy (low)    | rot_x rot_y rot_z (Q3.20)
//  result    | done (1-cycle pulse) | r00 .. r22 (Q1.22, row by row)
//
//  One vector accepted per cycle; busy is tied low.
//  The 24 square-root steps, 30 CORDIC steps and 33 divider steps make
//  up most of the pipeline, one step per stage.
//  Synchronous reset clears the valid chain only; payload is not reset.
//  No stalls: the receiver takes every done transaction.
module rotation_vector_to_matrix_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] rot_x,
  input  logic signed [23:0] rot_y,
  input  logic signed [23:0] rot_z,
  output logic               done,
  output logic signed [23:0] r00,
  output logic signed [23:0] r01,
  output logic signed [23:0] r02,
  output logic signed [23:0] r10,
  output logic signed [23:0] r11,
  output logic signed [23:0] r12,
  output logic signed [23:0] r20,
  output logic signed [23:0] r21,
  output logic signed [23:0] r22
);

  localparam int SQN = rv2m_pkg::SQRT_STEPS;
  localparam int CRN = rv2m_pkg::CORDIC_STEPS;
  localparam int DVN = rv2m_pkg::DIV_STEPS;
  localparam int CTN = rv2m_pkg::CTX_DEPTH;

  assign busy = 1'b0;

  // ---------------- stage p1: squares and cross products
  logic               p1_vld;
  logic signed [23:0] p1_wx, p1_wy, p1_wz;
  logic [46:0]        p1_xx, p1_yy, p1_zz;
  logic signed [47:0] p1_xy, p1_xz, p1_yz;
  logic signed [47:0] sq_x, sq_y, sq_z;

  assign sq_x = 48'(rot_x) * 48'(rot_x);
  assign sq_y = 48'(rot_y) * 48'(rot_y);
  assign sq_z = 48'(rot_z) * 48'(rot_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    p1_wx <= rot_x;
    p1_wy <= rot_y;
    p1_wz <= rot_z;
    p1_xx <= sq_x[46:0];
    p1_yy <= sq_y[46:0];
    p1_zz <= sq_z[46:0];
    p1_xy <= 48'(rot_x) * 48'(rot_y);
    p1_xz <= 48'(rot_x) * 48'(rot_z);
    p1_yz <= 48'(rot_y) * 48'(rot_z);
  end

  // ---------------- context chain
  rv2m_pkg::ctx_t ctx [CTN];
  logic [CTN-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[CTN-2:0], p1_vld};
    end
  end

  // stage 0: angle squared, Q.22 sums, angle class
  logic [47:0]    s_yz, s_xz, s_xy, s_t;
  rv2m_pkg::ctx_t c0;

  assign s_yz = 48'(p1_yy) + 48'(p1_zz);
  assign s_xz = 48'(p1_xx) + 48'(p1_zz);
  assign s_xy = 48'(p1_xx) + 48'(p1_yy);
  assign s_t  = 48'(p1_xx) + s_yz;

  always_comb begin
    c0      = '0;
    c0.wx   = p1_wx;
    c0.wy   = p1_wy;
    c0.wz   = p1_wz;
    c0.t    = s_t;
    c0.d0   = signed'({1'b0, s_yz[47:18]});
    c0.d1   = signed'({1'b0, s_xz[47:18]});
    c0.d2   = signed'({1'b0, s_xy[47:18]});
    c0.cxy  = 31'(p1_xy >>> 18);
    c0.cxz  = 31'(p1_xz >>> 18);
    c0.cyz  = 31'(p1_yz >>> 18);
    c0.tiny = s_t < rv2m_pkg::TINY_T;
    c0.gen  = s_t >= rv2m_pkg::SMALL_T;
  end

  // stages 1..3: series coefficients for small angles
  rv2m_pkg::ctx_t c1, c2, c3;
  logic [50:0] m_k6, m_k20, m_k24;
  logic [60:0] m_c6;
  logic [51:0] m_tc;

  always_comb begin
    c1    = ctx[0];
    m_k6  = 51'(ctx[0].t[20:0]) * 51'(rv2m_pkg::K6);
    m_k20 = 51'(ctx[0].t[20:0]) * 51'(rv2m_pkg::K20);
    m_k24 = 51'(ctx[0].t[20:0]) * 51'(rv2m_pkg::K24);
    c1.sa = rv2m_pkg::ONE_Q30 - 31'(m_k6 >> 42);
    c1.sc = rv2m_pkg::ONE_Q30 - 31'(m_k20 >> 42);
    if (ctx[0].tiny) begin
      c1.sb = rv2m_pkg::HALF_Q30;
    end else begin
      c1.sb = rv2m_pkg::HALF_Q30 - 31'(m_k24 >> 42);
    end
  end

  always_comb begin
    c2    = ctx[1];
    m_c6  = 61'(ctx[1].sc) * 61'(rv2m_pkg::K6);
    c2.sc = 31'(m_c6 >> 32);
  end

  always_comb begin
    c3   = ctx[2];
    m_tc = 52'(ctx[2].t[20:0]) * 52'(ctx[2].sc);
    if (!ctx[2].tiny) begin
      c3.sa = rv2m_pkg::ONE_Q30 - 31'(m_tc >> 40);
    end
  end

  always_ff @(posedge clk) begin
    ctx[0] <= c0;
    ctx[1] <= c1;
    ctx[2] <= c2;
    ctx[3] <= c3;
  end

  // ---------------- square root, one result bit per stage
  logic [25:0] sq_rem  [SQN];
  logic [23:0] sq_root [SQN];

  for (genvar j = 0; j < SQN; j++) begin : g_sqrt
    logic [25:0] rem_in;
    logic [23:0] root_in;
    logic [27:0] rem2, trial;
    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = sq_rem[j-1];
      assign root_in = sq_root[j-1];
    end
    assign rem2  = {rem_in, ctx[rv2m_pkg::IDX_SQ+j-1].t[2*(SQN-1-j)+1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    always_ff @(posedge clk) begin
      if (rem2 >= trial) begin
        sq_rem[j]  <= 26'(rem2 - trial);
        sq_root[j] <= {root_in[22:0], 1'b1};
      end else begin
        sq_rem[j]  <= rem2[25:0];
        sq_root[j] <= {root_in[22:0], 1'b0};
      end
    end
  end

  // ---------------- range reduction and fold
  logic signed [36:0] ang, ang_d1, ang_d2, ang_d3;
  logic signed [36:0] red_ang;
  logic signed [33:0] fold_z;
  logic               fold_neg;

  assign ang    = signed'({3'b000, sq_root[SQN-1], 10'b0});
  assign ang_d1 = ang - rv2m_pkg::TWO_PI_Q30;
  assign ang_d2 = ang - rv2m_pkg::FOUR_PI_Q30;
  assign ang_d3 = ang - rv2m_pkg::SIX_PI_Q30;

  always_ff @(posedge clk) begin
    priority if (ang <= rv2m_pkg::PI_Q30) begin
      red_ang <= ang;
    end else if (ang_d1 <= rv2m_pkg::PI_Q30) begin
      red_ang <= ang_d1;
    end else if (ang_d2 <= rv2m_pkg::PI_Q30) begin
      red_ang <= ang_d2;
    end else begin
      red_ang <= ang_d3;
    end
  end

  assign fold_neg = (red_ang > rv2m_pkg::HALF_PI_Q30) || (red_ang < -rv2m_pkg::HALF_PI_Q30);

  always_ff @(posedge clk) begin
    priority if (red_ang > rv2m_pkg::HALF_PI_Q30) begin
      fold_z <= 34'(rv2m_pkg::PI_Q30 - red_ang);
    end else if (red_ang < -rv2m_pkg::HALF_PI_Q30) begin
      fold_z <= 34'(-rv2m_pkg::PI_Q30 - red_ang);
    end else begin
      fold_z <= 34'(red_ang);
    end
  end

  // ---------------- CORDIC rotation, one micro-rotation per stage
  logic signed [33:0] cx [CRN];
  logic signed [33:0] cy [CRN];
  logic signed [33:0] cz [CRN];

  for (genvar i = 0; i < CRN; i++) begin : g_cordic
    logic signed [33:0] x_in, y_in, z_in, at;
    if (i == 0) begin : g_first
      assign x_in = rv2m_pkg::GAIN_Q30;
      assign y_in = '0;
      assign z_in = fold_z;
    end else begin : g_next
      assign x_in = cx[i-1];
      assign y_in = cy[i-1];
      assign z_in = cz[i-1];
    end
    assign at = signed'({2'b00, rv2m_pkg::ATAN_TAB[i]});
    always_ff @(posedge clk) begin
      if (!z_in[33]) begin
        cx[i] <= x_in - (y_in >>> i);
        cy[i] <= y_in + (x_in >>> i);
        cz[i] <= z_in - at;
      end else begin
        cx[i] <= x_in + (y_in >>> i);
        cy[i] <= y_in - (x_in >>> i);
        cz[i] <= z_in + at;
      end
    end
  end

  // ---------------- divider operands
  logic signed [33:0] cos_v, sin_v;
  logic signed [34:0] omc_w;
  logic [31:0]        pr_mag, pr_omc;

  assign sin_v = cy[CRN-1];
  assign cos_v = ctx[rv2m_pkg::IDX_PREP-1].neg ? -cx[CRN-1] : cx[CRN-1];
  assign omc_w = signed'(35'(rv2m_pkg::ONE_Q30)) - 35'(cos_v);

  always_ff @(posedge clk) begin
    pr_mag <= 32'(sin_v[33] ? -sin_v : sin_v);
    pr_omc <= omc_w[34] ? '0 : 32'(omc_w);
  end

  // context passes through; root, fold sign and sine sign join on the way
  for (genvar k = rv2m_pkg::IDX_SQ; k < CTN; k++) begin : g_ctx
    if (k == rv2m_pkg::IDX_RED) begin : g_th
      rv2m_pkg::ctx_t ctx_next;
      always_comb begin
        ctx_next    = ctx[k-1];
        ctx_next.th = sq_root[SQN-1];
      end
      always_ff @(posedge clk) begin
        ctx[k] <= ctx_next;
      end
    end else if (k == rv2m_pkg::IDX_FOLD) begin : g_neg
      rv2m_pkg::ctx_t ctx_next;
      always_comb begin
        ctx_next     = ctx[k-1];
        ctx_next.neg = fold_neg;
      end
      always_ff @(posedge clk) begin
        ctx[k] <= ctx_next;
      end
    end else if (k == rv2m_pkg::IDX_PREP) begin : g_sgn
      rv2m_pkg::ctx_t ctx_next;
      always_comb begin
        ctx_next     = ctx[k-1];
        ctx_next.sgn = sin_v[33];
      end
      always_ff @(posedge clk) begin
        ctx[k] <= ctx_next;
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        ctx[k] <= ctx[k-1];
      end
    end
  end

  // ---------------- restoring dividers, one quotient bit per stage
  // A: |sin| * 2^20 / theta   B: (1 - cos) * 2^40 / theta^2
  logic [23:0] da_rem [DVN];
  logic [32:0] da_q   [DVN];
  logic [47:0] db_rem [DVN];
  logic [32:0] db_q   [DVN];

  for (genvar j = 0; j < DVN; j++) begin : g_div
    logic [23:0] ra_in;
    logic [32:0] qa_in;
    logic [47:0] rb_in;
    logic [32:0] qb_in;
    logic [24:0] ra2;
    logic [48:0] rb2;
    logic [23:0] den_a;
    logic [47:0] den_b;
    if (j == 0) begin : g_first
      assign ra_in = {5'b0, pr_mag[31:13]};
      assign qa_in = {pr_mag[12:0], 20'b0};
      assign rb_in = {9'b0, pr_omc, 7'b0};
      assign qb_in = '0;
    end else begin : g_next
      assign ra_in = da_rem[j-1];
      assign qa_in = da_q[j-1];
      assign rb_in = db_rem[j-1];
      assign qb_in = db_q[j-1];
    end
    assign den_a = ctx[rv2m_pkg::IDX_PREP+j].th;
    assign den_b = ctx[rv2m_pkg::IDX_PREP+j].t;
    assign ra2   = {ra_in, qa_in[32]};
    assign rb2   = {rb_in, qb_in[32]};
    always_ff @(posedge clk) begin
      if (ra2 >= {1'b0, den_a}) begin
        da_rem[j] <= 24'(ra2 - {1'b0, den_a});
        da_q[j]   <= {qa_in[31:0], 1'b1};
      end else begin
        da_rem[j] <= ra2[23:0];
        da_q[j]   <= {qa_in[31:0], 1'b0};
      end
      if (rb2 >= {1'b0, den_b}) begin
        db_rem[j] <= 48'(rb2 - {1'b0, den_b});
        db_q[j]   <= {qb_in[31:0], 1'b1};
      end else begin
        db_rem[j] <= rb2[47:0];
        db_q[j]   <= {qb_in[31:0], 1'b0};
      end
    end
  end

  // ---------------- coefficient select
  logic               sel_vld;
  logic signed [33:0] sel_a, sel_b;
  logic signed [30:0] sel_d0, sel_d1, sel_d2, sel_cxy, sel_cxz, sel_cyz;
  logic signed [23:0] sel_wx, sel_wy, sel_wz;
  logic [33:0]        qa_ext;

  assign qa_ext = {1'b0, da_q[DVN-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_vld <= 1'b0;
    end else begin
      sel_vld <= vld[CTN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctx[CTN-1].gen) begin
      sel_a <= ctx[CTN-1].sgn ? signed'(-qa_ext) : signed'(qa_ext);
      sel_b <= signed'({1'b0, db_q[DVN-1]});
    end else begin
      sel_a <= signed'(34'(ctx[CTN-1].sa));
      sel_b <= signed'(34'(ctx[CTN-1].sb));
    end
    sel_d0  <= ctx[CTN-1].d0;
    sel_d1  <= ctx[CTN-1].d1;
    sel_d2  <= ctx[CTN-1].d2;
    sel_cxy <= ctx[CTN-1].cxy;
    sel_cxz <= ctx[CTN-1].cxz;
    sel_cyz <= ctx[CTN-1].cyz;
    sel_wx  <= ctx[CTN-1].wx;
    sel_wy  <= ctx[CTN-1].wy;
    sel_wz  <= ctx[CTN-1].wz;
  end

  // ---------------- products
  logic               m_vld;
  logic signed [64:0] m_d0, m_d1, m_d2, m_xy, m_xz, m_yz;
  logic signed [57:0] m_ax, m_ay, m_az;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= sel_vld;
    end
  end

  always_ff @(posedge clk) begin
    m_d0 <= 65'(sel_b) * 65'(sel_d0);
    m_d1 <= 65'(sel_b) * 65'(sel_d1);
    m_d2 <= 65'(sel_b) * 65'(sel_d2);
    m_xy <= 65'(sel_b) * 65'(sel_cxy);
    m_xz <= 65'(sel_b) * 65'(sel_cxz);
    m_yz <= 65'(sel_b) * 65'(sel_cyz);
    m_ax <= 58'(sel_a) * 58'(sel_wx);
    m_ay <= 58'(sel_a) * 58'(sel_wy);
    m_az <= 58'(sel_a) * 58'(sel_wz);
  end

  // ---------------- combine, clamp, drive result
  logic signed [39:0] e0, e1, e2, bxy, bxz, byz, ax, ay, az;

  assign e0  = rv2m_pkg::OUT_ONE - 40'(m_d0 >>> 30);
  assign e1  = rv2m_pkg::OUT_ONE - 40'(m_d1 >>> 30);
  assign e2  = rv2m_pkg::OUT_ONE - 40'(m_d2 >>> 30);
  assign bxy = 40'(m_xy >>> 30);
  assign bxz = 40'(m_xz >>> 30);
  assign byz = 40'(m_yz >>> 30);
  assign ax  = 40'(m_ax >>> 28);
  assign ay  = 40'(m_ay >>> 28);
  assign az  = 40'(m_az >>> 28);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    r00 <= rv2m_pkg::sat24(e0);
    r11 <= rv2m_pkg::sat24(e1);
    r22 <= rv2m_pkg::sat24(e2);
    r01 <= rv2m_pkg::sat24(bxy - az);
    r10 <= rv2m_pkg::sat24(bxy + az);
    r02 <= rv2m_pkg::sat24(bxz + ay);
    r20 <= rv2m_pkg::sat24(bxz - ay);
    r12 <= rv2m_pkg::sat24(byz - ax);
    r21 <= rv2m_pkg::sat24(byz + ax);
  end

endmodule

// File: rtl/rv2m_chk.sv
// ----------------------------------------------------------------------------
// Rotation vector to matrix: port checker
// Busy, latency, strobe origin and output range seen at the top-level ports.
// ----------------------------------------------------------------------------
module rv2m_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [23:0] r00,
  input logic signed [23:0] r01,
  input logic signed [23:0] r02,
  input logic signed [23:0] r10,
  input logic signed [23:0] r11,
  input logic signed [23:0] r12,
  input logic signed [23:0] r20,
  input logic signed [23:0] r21,
  input logic signed [23:0] r22
);

  localparam logic signed [23:0] LIM = 24'sd4194304;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy asserted");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##98 done)
    else $error("result missing after accepted transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 98))
    else $error("result without accepted transaction");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (r00 <= LIM && r00 >= -LIM && r01 <= LIM && r01 >= -LIM &&
              r02 <= LIM && r02 >= -LIM && r10 <= LIM && r10 >= -LIM &&
              r11 <= LIM && r11 >= -LIM && r12 <= LIM && r12 >= -LIM &&
              r20 <= LIM && r20 >= -LIM && r21 <= LIM && r21 >= -LIM &&
              r22 <= LIM && r22 >= -LIM))
    else $error("matrix entry out of range");

endmodule

bind rotation_vector_to_matrix_core rv2m_chk u_rv2m_chk (.*);
